// ===== rtl/core/adhm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers of the arcade drive mixer.
package adhm_pkg;

  localparam int CmdW  = 16;
  localparam int MagW  = 15;
  localparam int WideW = 2 * MagW;
  localparam int SumW  = MagW + 2;

  localparam logic [MagW-1:0] FULL_SCALE     = 15'h7FFF;
  localparam logic [MagW-1:0] DEADBAND_RESET = 15'd3277;
  localparam logic [7:0]      DUTY_MAX       = 8'd255;

  localparam int InW  = 40;
  localparam int OutW = 24;

  // Stage map of the pipeline
  localparam int StClamp = 0;
  localparam int StDband = 1;
  localparam int StNumer = 2;
  localparam int StDiv0  = 3;
  localparam int StShape = StDiv0 + MagW;
  localparam int StSq    = StShape + 1;
  localparam int StMix   = StSq + 1;
  localparam int StScale = StMix + 1;
  localparam int StDuty  = StScale + 1;
  localparam int NumSt   = StDuty + 1;

  typedef struct packed {
    logic              neg;
    logic              zero;
    logic [MagW-1:0]   q;
    logic [WideW-1:0]  rem;
    logic [WideW-1:0]  prod;
  } lane_t;

  typedef struct packed {
    logic  sq;
    lane_t x;
    lane_t z;
  } item_t;

  // floor(p / 32767) for p below 2^30, using 32767 = 2^15 - 1
  function automatic logic [MagW-1:0] div_fs(input logic [WideW-1:0] p);
    logic [MagW:0]   t;
    logic [MagW-1:0] q0;
    logic [1:0]      add;
    q0 = p[WideW-1:MagW];
    t  = {1'b0, q0} + {1'b0, p[MagW-1:0]};
    if (t >= {FULL_SCALE, 1'b0}) begin
      add = 2'd2;
    end else if (t >= {1'b0, FULL_SCALE}) begin
      add = 2'd1;
    end else begin
      add = 2'd0;
    end
    return q0 + {{(MagW-2){1'b0}}, add};
  endfunction

  // Clamp a signed sum to +/-32767 and split it into sign and magnitude
  function automatic logic [MagW:0] clamp_mag(input logic signed [SumW-1:0] v);
    logic            neg;
    logic [SumW-1:0] a;
    logic [MagW-1:0] m;
    neg = v[SumW-1];
    a   = neg ? SumW'(-v) : SumW'(v);
    m   = (a > {2'b00, FULL_SCALE}) ? FULL_SCALE : a[MagW-1:0];
    return {neg, m};
  endfunction

endpackage

// ===== rtl/core/arcade_drive_hbridge_mixer.sv =====
`timescale 1ns / 1ps
// Top level of the arcade drive mixer: shaping, mixing and H-bridge output pipeline.
//
// Arcade drive mixer for a two-motor H-bridge. Each transfer on the s_ side carries a
// forward-speed command, a rotation command (signed Q1.15, clamped to +/-32767) and a
// squaring flag; each transfer on the m_ side carries the left and right 8-bit PWM duty
// and the two H-bridge pin levels per side (zero power brakes: both pins high, duty 255;
// the right bridge has inverted pin polarity). The datapath is a 23-stage pipeline that
// takes one command every clock while m_tready does not stall the output; the depth is set
// by the deadband rescale, a 15-bit restoring divide by (32767 - deadband) resolved one
// quotient bit per stage. Each stage has its own valid bit and moves whenever the stage
// after it is free, so bubbles close up while a result waits on m_tready. The deadband
// register is written through cfg_we/cfg_wdata and must only change with the pipeline
// empty.
module arcade_drive_hbridge_mixer (
  input  logic                      clk,
  input  logic                      rst,
  // deadband configuration
  input  logic                      cfg_we,
  input  logic [adhm_pkg::MagW-1:0] cfg_wdata,
  // command stream
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // [15:0] speed_cmd, [31:16] rotation_cmd, [32] square_inputs, [39:33] zero
  input  logic [adhm_pkg::InW-1:0]  s_tdata,
  // drive stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // [7:0] left_duty, [8] left_fwd_pin, [9] left_rev_pin, [17:10] right_duty,
  // [18] right_fwd_pin, [19] right_rev_pin, [23:20] zero
  output logic [adhm_pkg::OutW-1:0] m_tdata
);

  localparam int NS = adhm_pkg::NumSt;
  localparam int MW = adhm_pkg::MagW;
  localparam int WW = adhm_pkg::WideW;
  localparam int SW = adhm_pkg::SumW;

  // Deadband and the divisor it implies, both kept in registers
  logic [MW-1:0] dband;
  logic [MW-1:0] divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      dband   <= adhm_pkg::DEADBAND_RESET;
      divisor <= adhm_pkg::FULL_SCALE - adhm_pkg::DEADBAND_RESET;
    end else if (cfg_we) begin
      dband   <= cfg_wdata;
      divisor <= adhm_pkg::FULL_SCALE - cfg_wdata;
    end
  end

  adhm_pkg::item_t pipe [NS];
  adhm_pkg::item_t nxt  [NS];
  logic [NS-1:0]   vld;
  logic [NS-1:0]   en;

  // Stage k may load when it is empty or its content moves on this cycle
  always_comb begin
    en[NS-1] = !vld[NS-1] || m_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        pipe[k] <= nxt[k];
      end
    end
  end

  // Clamp: take sign and magnitude, folding -32768 onto -32767
  function automatic adhm_pkg::lane_t take_cmd(input logic [adhm_pkg::CmdW-1:0] v);
    adhm_pkg::lane_t l;
    l      = '0;
    l.neg  = v[adhm_pkg::CmdW-1];
    if (v == {1'b1, {(adhm_pkg::CmdW-1){1'b0}}}) begin
      l.q = adhm_pkg::FULL_SCALE;
    end else begin
      l.q = l.neg ? MW'(-v) : v[MW-1:0];
    end
    return l;
  endfunction

  always_comb begin
    nxt[adhm_pkg::StClamp]    = '0;
    nxt[adhm_pkg::StClamp].sq = s_tdata[32];
    nxt[adhm_pkg::StClamp].x  = take_cmd(s_tdata[15:0]);
    nxt[adhm_pkg::StClamp].z  = take_cmd(s_tdata[31:16]);
  end

  // Deadband: flag commands inside it, keep the excess above it
  always_comb begin
    nxt[adhm_pkg::StDband]        = pipe[adhm_pkg::StDband-1];
    nxt[adhm_pkg::StDband].x.zero = pipe[adhm_pkg::StDband-1].x.q <= dband;
    nxt[adhm_pkg::StDband].z.zero = pipe[adhm_pkg::StDband-1].z.q <= dband;
    nxt[adhm_pkg::StDband].x.q    = pipe[adhm_pkg::StDband-1].x.q - dband;
    nxt[adhm_pkg::StDband].z.q    = pipe[adhm_pkg::StDband-1].z.q - dband;
  end

  // Numerator: excess * 32767, clear the quotient for the divider
  always_comb begin
    nxt[adhm_pkg::StNumer]       = pipe[adhm_pkg::StNumer-1];
    nxt[adhm_pkg::StNumer].x.rem = {pipe[adhm_pkg::StNumer-1].x.q, {MW{1'b0}}}
                                 - {{MW{1'b0}}, pipe[adhm_pkg::StNumer-1].x.q};
    nxt[adhm_pkg::StNumer].z.rem = {pipe[adhm_pkg::StNumer-1].z.q, {MW{1'b0}}}
                                 - {{MW{1'b0}}, pipe[adhm_pkg::StNumer-1].z.q};
    nxt[adhm_pkg::StNumer].x.q   = '0;
    nxt[adhm_pkg::StNumer].z.q   = '0;
  end

  // Restoring divide, one quotient bit per stage, most significant first
  for (genvar j = 0; j < MW; j++) begin : g_div
    localparam int B = MW - 1 - j;
    logic [WW-1:0] dsh;
    assign dsh = {{MW{1'b0}}, divisor} << B;
    always_comb begin
      nxt[adhm_pkg::StDiv0+j] = pipe[adhm_pkg::StDiv0+j-1];
      if (pipe[adhm_pkg::StDiv0+j-1].x.rem >= dsh) begin
        nxt[adhm_pkg::StDiv0+j].x.rem  = pipe[adhm_pkg::StDiv0+j-1].x.rem - dsh;
        nxt[adhm_pkg::StDiv0+j].x.q[B] = 1'b1;
      end
      if (pipe[adhm_pkg::StDiv0+j-1].z.rem >= dsh) begin
        nxt[adhm_pkg::StDiv0+j].z.rem  = pipe[adhm_pkg::StDiv0+j-1].z.rem - dsh;
        nxt[adhm_pkg::StDiv0+j].z.q[B] = 1'b1;
      end
    end
  end

  // Apply the deadband zero and form the square
  logic [MW-1:0] shp_x;
  logic [MW-1:0] shp_z;
  assign shp_x = pipe[adhm_pkg::StShape-1].x.zero ? '0 : pipe[adhm_pkg::StShape-1].x.q;
  assign shp_z = pipe[adhm_pkg::StShape-1].z.zero ? '0 : pipe[adhm_pkg::StShape-1].z.q;

  always_comb begin
    nxt[adhm_pkg::StShape]        = pipe[adhm_pkg::StShape-1];
    nxt[adhm_pkg::StShape].x.q    = shp_x;
    nxt[adhm_pkg::StShape].z.q    = shp_z;
    nxt[adhm_pkg::StShape].x.prod = {{MW{1'b0}}, shp_x} * {{MW{1'b0}}, shp_x};
    nxt[adhm_pkg::StShape].z.prod = {{MW{1'b0}}, shp_z} * {{MW{1'b0}}, shp_z};
  end

  // Squaring: scale the square back to Q1.15 when requested
  always_comb begin
    nxt[adhm_pkg::StSq] = pipe[adhm_pkg::StSq-1];
    if (pipe[adhm_pkg::StSq-1].sq) begin
      nxt[adhm_pkg::StSq].x.q = adhm_pkg::div_fs(pipe[adhm_pkg::StSq-1].x.prod);
      nxt[adhm_pkg::StSq].z.q = adhm_pkg::div_fs(pipe[adhm_pkg::StSq-1].z.prod);
    end
  end

  // Quadrant mix: x lane becomes left power, z lane becomes right power
  logic signed [SW-1:0] sx;
  logic signed [SW-1:0] sz;
  logic signed [SW-1:0] smax;
  logic signed [SW-1:0] pl;
  logic signed [SW-1:0] pr;
  logic [MW-1:0]        mx;
  logic [MW:0]          cl;
  logic [MW:0]          cr;

  always_comb begin
    mx   = (pipe[adhm_pkg::StMix-1].x.q > pipe[adhm_pkg::StMix-1].z.q) ?
           pipe[adhm_pkg::StMix-1].x.q : pipe[adhm_pkg::StMix-1].z.q;
    sx   = pipe[adhm_pkg::StMix-1].x.neg ? -$signed({2'b00, pipe[adhm_pkg::StMix-1].x.q})
                                         :  $signed({2'b00, pipe[adhm_pkg::StMix-1].x.q});
    sz   = pipe[adhm_pkg::StMix-1].z.neg ? -$signed({2'b00, pipe[adhm_pkg::StMix-1].z.q})
                                         :  $signed({2'b00, pipe[adhm_pkg::StMix-1].z.q});
    smax = sx[SW-1] ? -$signed({2'b00, mx}) : $signed({2'b00, mx});
    if (sx[SW-1] == sz[SW-1]) begin
      pl = smax;
      pr = sx - sz;
    end else begin
      pl = sx + sz;
      pr = smax;
    end
    cl = adhm_pkg::clamp_mag(pl);
    cr = adhm_pkg::clamp_mag(pr);
    nxt[adhm_pkg::StMix]        = pipe[adhm_pkg::StMix-1];
    nxt[adhm_pkg::StMix].x.neg  = cl[MW];
    nxt[adhm_pkg::StMix].x.q    = cl[MW-1:0];
    nxt[adhm_pkg::StMix].x.zero = cl[MW-1:0] == '0;
    nxt[adhm_pkg::StMix].z.neg  = cr[MW];
    nxt[adhm_pkg::StMix].z.q    = cr[MW-1:0];
    nxt[adhm_pkg::StMix].z.zero = cr[MW-1:0] == '0;
  end

  // Duty scale: magnitude * 255
  always_comb begin
    nxt[adhm_pkg::StScale]        = pipe[adhm_pkg::StScale-1];
    nxt[adhm_pkg::StScale].x.prod = {{MW{1'b0}}, pipe[adhm_pkg::StScale-1].x.q}
                                  * WW'(adhm_pkg::DUTY_MAX);
    nxt[adhm_pkg::StScale].z.prod = {{MW{1'b0}}, pipe[adhm_pkg::StScale-1].z.q}
                                  * WW'(adhm_pkg::DUTY_MAX);
  end

  // Duty: divide by full scale, hold 255 while braking
  always_comb begin
    nxt[adhm_pkg::StDuty]     = pipe[adhm_pkg::StDuty-1];
    nxt[adhm_pkg::StDuty].x.q = pipe[adhm_pkg::StDuty-1].x.zero ?
                                MW'(adhm_pkg::DUTY_MAX) :
                                adhm_pkg::div_fs(pipe[adhm_pkg::StDuty-1].x.prod);
    nxt[adhm_pkg::StDuty].z.q = pipe[adhm_pkg::StDuty-1].z.zero ?
                                MW'(adhm_pkg::DUTY_MAX) :
                                adhm_pkg::div_fs(pipe[adhm_pkg::StDuty-1].z.prod);
  end

  // Output: last stage drives the master side directly; right pins are inverted
  adhm_pkg::lane_t ol;
  adhm_pkg::lane_t orr;
  assign ol  = pipe[NS-1].x;
  assign orr = pipe[NS-1].z;

  assign m_tvalid = vld[NS-1];
  assign m_tdata  = {4'b0000,
                     orr.zero | !orr.neg, orr.zero | orr.neg, orr.q[7:0],
                     ol.zero | ol.neg,    ol.zero | !ol.neg,  ol.q[7:0]};

  // After the last quotient bit the remainder is below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (vld[adhm_pkg::StShape-1] && !pipe[adhm_pkg::StShape-1].x.zero)
      |-> (pipe[adhm_pkg::StShape-1].x.rem < {{MW{1'b0}}, divisor}))
    else $error("divider remainder not below divisor");

  // Input is refused only when every stage holds an item
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (&vld))
    else $error("input stalled with a free pipeline stage");

  // A result appears only by moving up from the stage before
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(vld[NS-1]) |-> $past(vld[NS-2]))
    else $error("result appeared without a source item");

endmodule
